// ===== rtl/srlm_pkg.sv =====
package srlm_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int Q_BITS      = 16;
   localparam int ALIGN_UP    = (SAMPLE_BITS < Q_BITS) ? Q_BITS - SAMPLE_BITS : 0;
   localparam int ALIGN_DOWN  = (SAMPLE_BITS > Q_BITS) ? SAMPLE_BITS - Q_BITS : 0;

   localparam int LEVEL_W    = 15;
   localparam int VOL_W      = 8;
   localparam int ALPHA_W    = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam int QUO_BITS  = 29;
   localparam int ROOT_BITS = 15;
   localparam int SH_W      = 2 * ROOT_BITS;
   localparam int REM_W     = 17;
   localparam int ALU_W     = REM_W + 2;
   localparam int STEP_W    = 5;
   localparam int MUL_W     = 17;
   localparam int PROD_W    = 2 * MUL_W;
   localparam int VNUM_W    = LEVEL_W + VOL_W;

   localparam logic [LEVEL_W-1:0]    LEVEL_MAX        = 15'd16384;
   localparam logic [ALPHA_W-1:0]    ALPHA_RESET      = 16'd4588;
   localparam logic [LEVEL_W-1:0]    FULL_SCALE_RESET = 15'd1638;
   localparam logic [VOL_W-1:0]      VOL_MAX          = 8'd255;
   localparam logic [CSR_IDX_W-1:0]  CSR_ALPHA        = 2'd0;
   localparam logic [CSR_IDX_W-1:0]  CSR_FULL_SCALE   = 2'd1;
   localparam logic [STEP_W-1:0]     DIV_STEPS_LAST   = 5'(QUO_BITS - 1);
   localparam logic [STEP_W-1:0]     ROOT_STEPS_LAST  = 5'(ROOT_BITS - 1);
   localparam logic [STEP_W-1:0]     VOL_STEPS_LAST   = 5'(VOL_W - 1);

   typedef enum logic [11:0] {
      ST_IDLE       = 12'b0000_0000_0001,
      ST_SQ_L       = 12'b0000_0000_0010,
      ST_SQ_R       = 12'b0000_0000_0100,
      ST_ACC        = 12'b0000_0000_1000,
      ST_DIV_INIT   = 12'b0000_0001_0000,
      ST_CNT_DIV    = 12'b0000_0010_0000,
      ST_ROOT       = 12'b0000_0100_0000,
      ST_SMOOTH_MUL = 12'b0000_1000_0000,
      ST_SMOOTH_ADD = 12'b0001_0000_0000,
      ST_VOL_SAT    = 12'b0010_0000_0000,
      ST_VOL_DIV    = 12'b0100_0000_0000,
      ST_OUT        = 12'b1000_0000_0000
   } state_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_sample;
      logic signed [SAMPLE_BITS-1:0] right_sample;
      logic                          block_end;
   } req_payload_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] block_rms;
      logic [LEVEL_W-1:0] smoothed_level;
      logic [VOL_W-1:0]   mapped_volume;
   } rsp_payload_type;

   typedef struct packed {
      logic req_fire;
      logic close_block;
      logic vol_sat;
      logic out_free;
   } status_type;

   typedef struct packed {
      state_type state;
      logic      last_step;
   } ctrl_type;

   function automatic logic signed [Q_BITS-1:0] align_sample(
      input logic signed [SAMPLE_BITS-1:0] raw);
      logic signed [SAMPLE_BITS+ALIGN_UP-1:0] wide;
      wide = (SAMPLE_BITS + ALIGN_UP)'(raw) <<< ALIGN_UP;
      return Q_BITS'(wide >>> ALIGN_DOWN);
   endfunction

endpackage

// ===== rtl/stereo_rms_level_meter.sv =====
// Stereo RMS level meter. Each transfer on the request channel is one stereo sample pair;
// its two squares are formed on a single shared multiplier and added to the block sum, and
// a pair that does not end a block runs through ST_SQ_L, ST_SQ_R and ST_ACC. The pair
// flagged as block_end, or the pair that brings the block to MAX_FRAMES, closes the
// block: a 29-step restoring division of the sum by eight times the pair count and a
// 15-step square root run on one shared compare-and-subtract unit, the smoothing update
// reuses the multiplier, and an 8-step division on the same unit gives the volume, unless
// the volume saturates. The result is then offered on the response channel, later if the
// previous result has not yet been taken, and req_ready stays low until then.
// Configuration writes are always accepted and should only be issued while the block is idle.
module stereo_rms_level_meter
   import srlm_pkg::*;
#(
   parameter int MAX_FRAMES = 1024
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_payload_type       req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_payload_type       rsp_payload,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int CNT_W = $clog2(MAX_FRAMES + 1);
   localparam int SUM_W = 2 * Q_BITS + CNT_W;

   ctrl_type   ctrl;
   status_type status;

   logic signed [Q_BITS-1:0]  left_ff, left_in, right_ff, right_in;
   logic                      last_pair_ff, last_pair_in;
   logic signed [MUL_W-1:0]   mul_a, mul_b;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic [SUM_W-1:0]          sum_ff, sum_in;
   logic [CNT_W-1:0]          count_ff, count_in, count_inc;
   logic [REM_W-1:0]          rem_ff, rem_in;
   logic [SH_W-1:0]           sh_ff, sh_in;
   logic [ROOT_BITS-1:0]      root_ff, root_in;
   logic [LEVEL_W-1:0]        level_ff, level_in;
   logic [ALPHA_W-1:0]        alpha_ff, alpha_in;
   logic [LEVEL_W-1:0]        fs_ff, fs_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_payload_type           rsp_payload_ff, rsp_payload_in;

   logic [ALU_W-1:0]          alu_a, alu_b, alu_diff;
   logic                      alu_ge;
   logic [LEVEL_W-1:0]        rms_w, fs_eff;
   logic [VNUM_W-1:0]         vnum;
   logic signed [MUL_W-1:0]   diff_w;
   logic signed [PROD_W-17:0] delta_w, lvl_w;
   logic                      req_fire, out_free, out_load;

   srlm_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   srlm_alu u_alu (
      .a    (alu_a),
      .b    (alu_b),
      .ge   (alu_ge),
      .diff (alu_diff)
   );

   assign req_ready = (ctrl.state == ST_IDLE);
   assign req_fire  = req_valid & req_ready;
   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign out_load  = (ctrl.state == ST_OUT) & out_free;
   assign count_inc = count_ff + CNT_W'(1);

   assign status.req_fire    = req_fire;
   assign status.close_block = last_pair_ff | (count_inc == CNT_W'(MAX_FRAMES));
   assign status.vol_sat     = alu_ge;
   assign status.out_free    = out_free;

   assign rms_w   = (root_ff > LEVEL_MAX) ? LEVEL_MAX : root_ff;
   assign fs_eff  = (fs_ff == '0) ? LEVEL_W'(1) : fs_ff;
   assign vnum    = {level_ff, VOL_W'(0)} - VNUM_W'(level_ff);
   assign diff_w  = $signed({2'b00, rms_w}) - $signed({2'b00, level_ff});
   assign delta_w = prod_ff[PROD_W-1:16];
   assign lvl_w   = $signed({3'b000, level_ff}) + delta_w;

   always_comb begin
      mul_a = MUL_W'(left_ff);
      mul_b = MUL_W'(left_ff);
      case (ctrl.state)
         ST_SQ_R: begin
            mul_a = MUL_W'(right_ff);
            mul_b = MUL_W'(right_ff);
         end
         ST_SMOOTH_MUL: begin
            mul_a = $signed({1'b0, alpha_ff});
            mul_b = diff_w;
         end
         default: begin
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   always_comb begin
      alu_a = '0;
      alu_b = '0;
      case (ctrl.state)
         ST_CNT_DIV: begin
            alu_a = ALU_W'({rem_ff, sh_ff[QUO_BITS-1]});
            alu_b = ALU_W'(count_ff);
         end
         ST_VOL_DIV: begin
            alu_a = ALU_W'({rem_ff, sh_ff[QUO_BITS-1]});
            alu_b = ALU_W'(fs_eff);
         end
         ST_ROOT: begin
            alu_a = {rem_ff, sh_ff[SH_W-1 -: 2]};
            alu_b = ALU_W'({root_ff, 2'b01});
         end
         ST_VOL_SAT: begin
            alu_a = ALU_W'(vnum[VNUM_W-2:VOL_W]);
            alu_b = ALU_W'(fs_eff);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      left_in        = left_ff;
      right_in       = right_ff;
      last_pair_in   = last_pair_ff;
      sum_in         = sum_ff;
      count_in       = count_ff;
      rem_in         = rem_ff;
      sh_in          = sh_ff;
      root_in        = root_ff;
      level_in       = level_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_ready;
      case (ctrl.state)
         ST_IDLE: begin
            if (req_fire) begin
               left_in      = align_sample(req_payload.left_sample);
               right_in     = align_sample(req_payload.right_sample);
               last_pair_in = req_payload.block_end;
            end
         end
         ST_SQ_R: begin
            sum_in = sum_ff + SUM_W'(prod_ff[2*Q_BITS-2:0]);
         end
         ST_ACC: begin
            sum_in   = sum_ff + SUM_W'(prod_ff[2*Q_BITS-2:0]);
            count_in = count_inc;
         end
         ST_DIV_INIT: begin
            rem_in = REM_W'(sum_ff[SUM_W-1:QUO_BITS+3]);
            sh_in  = SH_W'(sum_ff[QUO_BITS+2:3]);
         end
         ST_CNT_DIV: begin
            rem_in = alu_ge ? REM_W'(alu_diff) : REM_W'(alu_a);
            sh_in  = {sh_ff[SH_W-2:0], alu_ge};
            if (ctrl.last_step) begin
               rem_in  = '0;
               root_in = '0;
               sh_in   = {1'b0, sh_ff[QUO_BITS-2:0], alu_ge};
            end
         end
         ST_ROOT: begin
            rem_in  = alu_ge ? REM_W'(alu_diff) : REM_W'(alu_a);
            root_in = {root_ff[ROOT_BITS-2:0], alu_ge};
            sh_in   = sh_ff << 2;
         end
         ST_SMOOTH_ADD: begin
            if (lvl_w[PROD_W-17]) begin
               level_in = '0;
            end else if (lvl_w[PROD_W-18:0] > (PROD_W-17)'(LEVEL_MAX)) begin
               level_in = LEVEL_MAX;
            end else begin
               level_in = LEVEL_W'(lvl_w);
            end
         end
         ST_VOL_SAT: begin
            if (alu_ge) begin
               sh_in = {sh_ff[SH_W-1:VOL_W], VOL_MAX};
            end else begin
               rem_in = REM_W'(vnum[VNUM_W-2:VOL_W]);
               sh_in  = SH_W'(vnum[VOL_W-1:0]) << (QUO_BITS - VOL_W);
            end
         end
         ST_VOL_DIV: begin
            rem_in = alu_ge ? REM_W'(alu_diff) : REM_W'(alu_a);
            sh_in  = {sh_ff[SH_W-2:0], alu_ge};
         end
         ST_OUT: begin
            if (out_load) begin
               rsp_payload_in.block_rms      = rms_w;
               rsp_payload_in.smoothed_level = level_ff;
               rsp_payload_in.mapped_volume  = sh_ff[VOL_W-1:0];
               rsp_valid_in                  = 1'b1;
               sum_in                        = '0;
               count_in                      = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      alpha_in = alpha_ff;
      fs_in    = fs_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ALPHA: begin
               alpha_in = csr_data[ALPHA_W-1:0];
            end
            CSR_FULL_SCALE: begin
               fs_in = csr_data[LEVEL_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         count_ff     <= '0;
         level_ff     <= '0;
         alpha_ff     <= ALPHA_RESET;
         fs_ff        <= FULL_SCALE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         level_ff     <= level_in;
         alpha_ff     <= alpha_in;
         fs_ff        <= fs_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff        <= left_in;
      right_ff       <= right_in;
      last_pair_ff   <= last_pair_in;
      prod_ff        <= prod_in;
      rem_ff         <= rem_in;
      sh_ff          <= sh_in;
      root_ff        <= root_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      (ctrl.state == ST_CNT_DIV) |-> (rem_ff < REM_W'(count_ff)))
      else $error("division remainder is not below the pair count");

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_FRAMES))
      else $error("pair count has run past the block limit");

   assert property (@(posedge clock) disable iff (reset)
      level_ff <= LEVEL_MAX)
      else $error("smoothed level is above full range");

   assert property (@(posedge clock) disable iff (reset)
      out_load |=> (rsp_valid && sum_ff == '0 && count_ff == '0 && ctrl.state == ST_IDLE))
      else $error("block state not cleared after result transfer was loaded");
`endif

endmodule

// ===== rtl/srlm_alu.sv =====
module srlm_alu
   import srlm_pkg::*;
(
   input  logic [ALU_W-1:0] a,
   input  logic [ALU_W-1:0] b,
   output logic             ge,
   output logic [ALU_W-1:0] diff
);

   logic [ALU_W:0] wide_diff;

   assign wide_diff = {1'b0, a} - {1'b0, b};
   assign ge        = ~wide_diff[ALU_W];
   assign diff      = wide_diff[ALU_W-1:0];

endmodule

// ===== rtl/srlm_seq.sv =====
module srlm_seq
   import srlm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  status_type status,
   output ctrl_type   ctrl
);

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (status.req_fire) begin
               state_in = ST_SQ_L;
            end
         end
         ST_SQ_L: begin
            state_in = ST_SQ_R;
         end
         ST_SQ_R: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            state_in = status.close_block ? ST_DIV_INIT : ST_IDLE;
         end
         ST_DIV_INIT: begin
            state_in = ST_CNT_DIV;
            step_in  = DIV_STEPS_LAST;
         end
         ST_CNT_DIV: begin
            if (step_ff == '0) begin
               state_in = ST_ROOT;
               step_in  = ROOT_STEPS_LAST;
            end else begin
               step_in = step_ff - STEP_W'(1);
            end
         end
         ST_ROOT: begin
            if (step_ff == '0) begin
               state_in = ST_SMOOTH_MUL;
            end else begin
               step_in = step_ff - STEP_W'(1);
            end
         end
         ST_SMOOTH_MUL: begin
            state_in = ST_SMOOTH_ADD;
         end
         ST_SMOOTH_ADD: begin
            state_in = ST_VOL_SAT;
         end
         ST_VOL_SAT: begin
            if (status.vol_sat) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_VOL_DIV;
               step_in  = VOL_STEPS_LAST;
            end
         end
         ST_VOL_DIV: begin
            if (step_ff == '0) begin
               state_in = ST_OUT;
            end else begin
               step_in = step_ff - STEP_W'(1);
            end
         end
         ST_OUT: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   assign ctrl.state     = state_ff;
   assign ctrl.last_step = (step_ff == '0);

endmodule
